[hdl/fpjlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpjlp_pkg;

    localparam logic [7:0]  HDR1_BYTE     = 8'hAE;
    localparam logic [7:0]  HDR2_BYTE     = 8'h53;
    localparam logic [7:0]  LF_BYTE       = 8'h0A;
    localparam logic [7:0]  CR_BYTE       = 8'h0D;
    localparam logic [7:0]  BRACE_BYTE    = 8'h7B;
    localparam logic [7:0]  BRACKET_BYTE  = 8'h5B;
    localparam logic [15:0] MAX_LEN_RESET = 16'd8192;
    localparam logic [3:0]  CR_HOLD_MAX   = 4'd15;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_VERDICT  = 2'd1;
    localparam logic [1:0] KIND_RAW_BYTE = 2'd2;
    localparam logic [1:0] KIND_RAW_END  = 2'd3;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_NO_TERM  = 2'd2;

    typedef enum logic [6:0] {
        PH_H1   = 7'b0000001,
        PH_H2   = 7'b0000010,
        PH_LEN1 = 7'b0000100,
        PH_LEN2 = 7'b0001000,
        PH_CHK  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_TERM = 7'b1000000
    } phase_t;

    // one input byte's results: cr_cnt held CRs, then one final result
    typedef struct packed {
        logic [3:0] cr_cnt;
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] status;
    } desc_t;

endpackage

`default_nettype wire

[hdl/fpjlp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpjlp_parser
    import fpjlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    output logic             push,
    output desc_t            push_desc
);

    logic [15:0] max_len_reg;
    phase_t      phase_reg,    phase_next;
    logic [15:0] flen_reg,     flen_next;
    logic [15:0] seen_reg,     seen_next;
    logic [7:0]  exp_sum_reg,  exp_sum_next;
    logic [7:0]  xor_reg,      xor_next;
    logic        raw_reg,      raw_next;
    logic [3:0]  held_reg,     held_next;
    logic [15:0] len_full;
    logic [15:0] seen_inc;

    assign len_full = {flen_reg[15:8], in_byte};
    assign seen_inc = seen_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        flen_next    = flen_reg;
        seen_next    = seen_reg;
        exp_sum_next = exp_sum_reg;
        xor_next     = xor_reg;
        raw_next     = raw_reg;
        held_next    = held_reg;
        push         = 1'b0;
        push_desc    = '{cr_cnt: 4'd0, kind: KIND_PAYLOAD, data: 8'd0, status: STATUS_GOOD};

        if (raw_reg) begin
            if (in_byte == LF_BYTE) begin
                held_next      = 4'd0;
                raw_next       = 1'b0;
                push           = 1'b1;
                push_desc.kind = KIND_RAW_END;
            end else if (in_byte == CR_BYTE) begin
                if (held_reg >= CR_HOLD_MAX) begin
                    push           = 1'b1;
                    push_desc.kind = KIND_RAW_BYTE;
                    push_desc.data = CR_BYTE;
                end else begin
                    held_next = held_reg + 4'd1;
                end
            end else begin
                push             = 1'b1;
                push_desc.cr_cnt = held_reg;
                push_desc.kind   = KIND_RAW_BYTE;
                push_desc.data   = in_byte;
                held_next        = 4'd0;
            end
        end else if (phase_reg == PH_H1 &&
                     (in_byte == BRACE_BYTE || in_byte == BRACKET_BYTE)) begin
            raw_next       = 1'b1;
            held_next      = 4'd0;
            push           = 1'b1;
            push_desc.kind = KIND_RAW_BYTE;
            push_desc.data = in_byte;
        end else begin
            case (phase_reg)
                PH_H2: begin
                    if (in_byte == HDR2_BYTE) begin
                        phase_next = PH_LEN1;
                    end else if (in_byte != HDR1_BYTE) begin
                        phase_next = PH_H1;
                    end
                end
                PH_LEN1: begin
                    flen_next  = {in_byte, 8'd0};
                    phase_next = PH_LEN2;
                end
                PH_LEN2: begin
                    flen_next = len_full;
                    if (len_full == 16'd0 || len_full > max_len_reg) begin
                        phase_next = PH_H1;
                    end else begin
                        seen_next  = 16'd0;
                        xor_next   = 8'd0;
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK: begin
                    exp_sum_next = in_byte;
                    phase_next   = PH_DATA;
                end
                PH_DATA: begin
                    xor_next  = xor_reg ^ in_byte;
                    seen_next = seen_inc;
                    if (seen_inc >= flen_reg) begin
                        phase_next = PH_TERM;
                    end
                    push           = 1'b1;
                    push_desc.kind = KIND_PAYLOAD;
                    push_desc.data = in_byte;
                end
                PH_TERM: begin
                    push           = 1'b1;
                    push_desc.kind = KIND_VERDICT;
                    if (in_byte != LF_BYTE) begin
                        push_desc.status = STATUS_NO_TERM;
                    end else if (xor_reg == exp_sum_reg) begin
                        push_desc.status = STATUS_GOOD;
                    end else begin
                        push_desc.status = STATUS_BAD_SUM;
                    end
                    phase_next = PH_H1;
                end
                default: begin
                    // header hunt
                    if (in_byte == HDR1_BYTE) begin
                        phase_next = PH_H2;
                    end else begin
                        phase_next = PH_H1;
                    end
                end
            endcase
        end

        if (!in_fire) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
            phase_reg   <= PH_H1;
            flen_reg    <= 16'd0;
            seen_reg    <= 16'd0;
            exp_sum_reg <= 8'd0;
            xor_reg     <= 8'd0;
            raw_reg     <= 1'b0;
            held_reg    <= 4'd0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                phase_reg   <= phase_next;
                flen_reg    <= flen_next;
                seen_reg    <= seen_next;
                exp_sum_reg <= exp_sum_next;
                xor_reg     <= xor_next;
                raw_reg     <= raw_next;
                held_reg    <= held_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/fpjlp_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpjlp_out_queue
    import fpjlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire desc_t       push_desc,
    output logic             in_ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic  head_valid_reg;
    desc_t head_reg;
    logic  skid_valid_reg;
    desc_t skid_reg;
    logic  head_done;
    logic  head_free;
    logic  cr_beat;

    assign in_ready  = !skid_valid_reg;
    assign cr_beat   = head_valid_reg && (head_reg.cr_cnt != 4'd0);
    assign head_done = head_valid_reg && m_tready && !cr_beat;
    assign head_free = !head_valid_reg || head_done;

    // held CRs go out first, then the final result of the request
    always_comb begin
        m_tvalid = head_valid_reg;
        m_tlast  = !cr_beat;
        if (cr_beat) begin
            m_tuser = KIND_RAW_BYTE;
            m_tdata = {6'd0, STATUS_GOOD, CR_BYTE};
        end else begin
            m_tuser = head_reg.kind;
            m_tdata = {6'd0, head_reg.status, head_reg.data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (head_free) begin
                if (skid_valid_reg) begin
                    head_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    head_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (head_free) begin
            if (skid_valid_reg) begin
                head_reg <= skid_reg;
            end else if (push) begin
                head_reg <= push_desc;
            end
        end else begin
            if (cr_beat && m_tready) begin
                head_reg.cr_cnt <= head_reg.cr_cnt - 4'd1;
            end
            if (push) begin
                skid_reg <= push_desc;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/framed_packet_and_json_line_parser.sv]
// a result is registered in the head slot, or in the skid slot if the head is held
// throughput: one byte per cycle while the skid slot is empty; a raw line byte after
//   held CRs goes out as one CR beat per held CR, then the byte itself
// reset: aresetn synchronous active low; parser returns to header hunt, the
//   length limit to 8192, and both result slots empty
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_and_json_line_parser
    import fpjlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,  // max_frame_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // [7:0] data_byte, [9:8] status, rest zero
    output logic [1:0]       m_tuser,      // [1:0] kind
    output logic             m_tlast
);

    logic  in_fire;
    logic  push;
    desc_t push_desc;

    assign in_fire = s_tvalid && s_tready;

    fpjlp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .push        (push),
        .push_desc   (push_desc)
    );

    fpjlp_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
